// ----- src/lbs_pkg.sv -----
package lbs_pkg;

	localparam int STEP_W = 8;
	localparam int PIN_W  = 8;
	localparam int MODE_W = 2;
	localparam int MS_W   = 16;
	localparam int KIND_W = 2;
	localparam int SLOT_W = 4;

	localparam logic [STEP_W-1:0] STEP_RESET = 8'd10;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COUNTED  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ENDLESS  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_INSERTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LEVEL    = 2'd2;

	typedef struct packed {
		logic              running;
		logic [MODE_W-1:0] mode;
		logic              started;
		logic              lit;
		logic [PIN_W-1:0]  pin;
		logic [MS_W-1:0]   on_reload;
		logic [MS_W-1:0]   off_reload;
		logic [MS_W-1:0]   on_left;
		logic [MS_W-1:0]   off_left;
		logic [MS_W-1:0]   blinks_left;
	} slot_rec_t;

	typedef struct packed {
		logic              op;
		logic [PIN_W-1:0]  pin;
		logic [MODE_W-1:0] mode;
		logic [MS_W-1:0]   on_ms;
		logic [MS_W-1:0]   off_ms;
		logic [MS_W-1:0]   blink_count;
	} item_t;

	typedef struct packed {
		logic claim;
		logic change;
		logic level;
	} slot_ev_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [PIN_W-1:0]  pin_out;
		logic              level;
		logic              last;
	} result_t;

endpackage

// ----- src/lbs_item_if.sv -----
interface lbs_item_if import lbs_pkg::*;;
	logic              valid;
	logic              ready;
	logic              op;
	logic [PIN_W-1:0]  pin;
	logic [MODE_W-1:0] mode;
	logic [MS_W-1:0]   on_ms;
	logic [MS_W-1:0]   off_ms;
	logic [MS_W-1:0]   blink_count;

	modport source (output valid, op, pin, mode, on_ms, off_ms, blink_count, input ready);
	modport sink (input valid, op, pin, mode, on_ms, off_ms, blink_count, output ready);
endinterface

// ----- src/lbs_result_if.sv -----
interface lbs_result_if import lbs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SLOT_W-1:0] slot;
	logic [PIN_W-1:0]  pin_out;
	logic              level;
	logic              last;

	modport source (output valid, kind, slot, pin_out, level, last, input ready);
	modport sink (input valid, kind, slot, pin_out, level, last, output ready);
endinterface

// ----- src/lbs_cell.sv -----
module lbs_cell import lbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  slot_rec_t d,
	output slot_rec_t q
);

	slot_rec_t rec_q;

	// whole record clears at reset, so an idle slot reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

// ----- src/lbs_slot_proc.sv -----
module lbs_slot_proc import lbs_pkg::*; (
	input  slot_rec_t         cur,
	input  item_t             item,
	input  logic [STEP_W-1:0] step,
	input  logic              found,
	output slot_rec_t         nxt,
	output slot_ev_t          ev
);

	logic [MS_W:0]   twice_step;
	logic [MS_W-1:0] step_ext;
	logic            on_exp;
	logic            off_exp;
	logic [MS_W-1:0] on_dec;
	logic [MS_W-1:0] off_dec;
	logic [MS_W-1:0] blinks_dec;

	// a phase expires when below the step now or after the subtraction
	assign twice_step = {{(MS_W-STEP_W){1'b0}}, step, 1'b0};
	assign step_ext   = {{(MS_W-STEP_W){1'b0}}, step};
	assign on_exp     = {1'b0, cur.on_left} < twice_step;
	assign off_exp    = {1'b0, cur.off_left} < twice_step;
	assign on_dec     = cur.on_left - step_ext;
	assign off_dec    = cur.off_left - step_ext;
	assign blinks_dec = cur.blinks_left - MS_W'(1);

	always_comb begin
		nxt = cur;
		ev  = '0;
		if (item.op == OP_INSERT) begin
			if (!found && !cur.running) begin
				ev.claim        = 1'b1;
				nxt.running     = 1'b1;
				nxt.mode        = item.mode;
				nxt.started     = 1'b0;
				nxt.lit         = 1'b0;
				nxt.pin         = item.pin;
				nxt.on_reload   = item.on_ms;
				nxt.on_left     = item.on_ms;
				nxt.off_reload  = (item.mode != MODE_ONE_SHOT) ? item.off_ms : '0;
				nxt.off_left    = (item.mode != MODE_ONE_SHOT) ? item.off_ms : '0;
				nxt.blinks_left = (item.mode == MODE_COUNTED) ? item.blink_count : '0;
			end
		end else if (cur.running) begin
			if (!cur.started) begin
				nxt.started = 1'b1;
				nxt.lit     = 1'b1;
				ev.change   = 1'b1;
				ev.level    = 1'b1;
			end else if (cur.mode == MODE_ONE_SHOT) begin
				if (on_exp) begin
					ev.change   = 1'b1;
					nxt.running = 1'b0;
					nxt.lit     = 1'b0;
				end else begin
					nxt.on_left = on_dec;
				end
			end else if (cur.lit) begin
				if (on_exp) begin
					ev.change = 1'b1;
					nxt.lit   = 1'b0;
					if (cur.mode == MODE_COUNTED) begin
						nxt.blinks_left = blinks_dec;
						if (blinks_dec == '0) begin
							nxt.running = 1'b0;
						end else begin
							nxt.on_left = cur.on_reload;
						end
					end else begin
						nxt.on_left = cur.on_reload;
					end
				end else begin
					nxt.on_left = on_dec;
				end
			end else begin
				if (off_exp) begin
					ev.change    = 1'b1;
					ev.level     = 1'b1;
					nxt.lit      = 1'b1;
					nxt.off_left = cur.off_reload;
				end else begin
					nxt.off_left = off_dec;
				end
			end
		end
	end

endmodule

// ----- src/multi_slot_led_blink_scheduler_unit.sv -----
// Slot records circulate through a ring of SLOT_COUNT cells; the head cell is
// updated and fed back to the tail once per cycle while the ring advances in S_RUN.
// An insert result is issued from S_FLUSH once the ring has made a full turn.
// One input word is taken at a time, the next only after its ring turn and flush;
// a stalled result side holds the ring while a level change waits.
// Reset: all slots idle, tick step back to 10 ms, no result pending.
module multi_slot_led_blink_scheduler_unit import lbs_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	lbs_item_if.sink          item,
	lbs_result_if.source      result,
	input  logic              tick_step_we,
	input  logic [STEP_W-1:0] tick_step_wdata
);

	localparam int CW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [CW-1:0] LAST_IDX = CW'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_RUN   = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [STEP_W-1:0] step_q;
	item_t             item_q;
	logic              found_q;
	logic [SLOT_W-1:0] found_slot_q;
	logic              pend_v_q;
	result_t           pend_q;
	logic              out_valid_q;
	result_t           out_q;

	slot_rec_t cell_q [SLOT_COUNT];
	slot_rec_t cell_d [SLOT_COUNT];
	slot_rec_t proc_nxt;
	slot_ev_t  proc_ev;

	logic    accept;
	logic    out_free;
	logic    advance;
	logic    load_out;
	result_t out_d;
	result_t new_ev;

	genvar gi;
	generate
		for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_ring
			if (gi == SLOT_COUNT - 1) begin : g_tail
				assign cell_d[gi] = proc_nxt;
			end else begin : g_link
				assign cell_d[gi] = cell_q[gi+1];
			end
			lbs_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (advance),
				.d      (cell_d[gi]),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	lbs_slot_proc u_proc (
		.cur   (cell_q[0]),
		.item  (item_q),
		.step  (step_q),
		.found (found_q),
		.nxt   (proc_nxt),
		.ev    (proc_ev)
	);

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	// a new level change may only displace the held one if the output can take it
	assign advance  = (state_q == S_RUN) && (!proc_ev.change || !pend_v_q || out_free);

	always_comb begin
		new_ev         = '0;
		new_ev.kind    = KIND_LEVEL;
		new_ev.slot    = SLOT_W'(cnt_q);
		new_ev.pin_out = cell_q[0].pin;
		new_ev.level   = proc_ev.level;
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		out_d    = pend_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (advance && proc_ev.change && pend_v_q) begin
					load_out   = 1'b1;
					out_d.last = 1'b0;
				end
				if (advance && cnt_q == LAST_IDX) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (item_q.op == OP_INSERT) begin
					out_d      = '0;
					out_d.kind = found_q ? KIND_INSERTED : KIND_FULL;
					out_d.slot = found_q ? found_slot_q : '0;
					out_d.last = 1'b1;
					if (out_free) begin
						load_out = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					load_out   = 1'b1;
					out_d.last = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= STEP_RESET;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick_step_we) begin
				step_q <= tick_step_wdata;
			end
			if (accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (advance) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + CW'(1);
				if (proc_ev.claim) begin
					found_q <= 1'b1;
				end
			end
			if (advance && proc_ev.change) begin
				pend_v_q <= 1'b1;
			end else if (state_q == S_FLUSH && load_out) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op          <= item.op;
			item_q.pin         <= item.pin;
			item_q.mode        <= item.mode;
			item_q.on_ms       <= item.on_ms;
			item_q.off_ms      <= item.off_ms;
			item_q.blink_count <= item.blink_count;
		end
		if (advance && proc_ev.claim) begin
			found_slot_q <= SLOT_W'(cnt_q);
		end
		if (advance && proc_ev.change) begin
			pend_q <= new_ev;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign item.ready     = (state_q == S_IDLE);
	assign result.valid   = out_valid_q;
	assign result.kind    = out_q.kind;
	assign result.slot    = out_q.slot;
	assign result.pin_out = out_q.pin_out;
	assign result.level   = out_q.level;
	assign result.last    = out_q.last;

endmodule

// ----- src/lbs_checker.sv -----
module lbs_checker import lbs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [KIND_W-1:0] result_kind,
	input logic [SLOT_W-1:0] result_slot,
	input logic [PIN_W-1:0]  result_pin_out,
	input logic              result_level,
	input logic              result_last
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_kind) &&
		$stable(result_slot) && $stable(result_pin_out) && $stable(result_level) &&
		$stable(result_last))
		else $error("result word changed while stalled");

	// one item at a time: input closes right after a word is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input stayed open after accept");

	// insert answers are single words
	a_insert_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == KIND_INSERTED || result_kind == KIND_FULL)
		|-> result_last)
		else $error("insert result without last");

	a_insert_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_LEVEL |-> result_pin_out == '0 && !result_level)
		else $error("insert result carries pin data");

endmodule

bind multi_slot_led_blink_scheduler_unit lbs_checker u_lbs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_kind    (result.kind),
	.result_slot    (result.slot),
	.result_pin_out (result.pin_out),
	.result_level   (result.level),
	.result_last    (result.last)
);
